/* src/jibe_pkg.sv */
// Shared types, opcode constants and width helpers for the JVM int bytecode executor.
// No dependencies; imported by every module of the block.
package jibe_pkg;

   localparam int DEF_STACK_DEPTH = 16;
   localparam int DEF_LOCAL_COUNT = 16;

   // request payload: opcode, operand_high, operand_low
   localparam int REQ_W   = 24;
   localparam int PC_W    = 16;
   localparam int WORD_W  = 32;

   // opcodes handled by the block
   localparam logic [7:0] OP_ICONST_M1 = 8'h02;
   localparam logic [7:0] OP_ICONST_5  = 8'h08;
   localparam logic [7:0] OP_BIPUSH    = 8'h10;
   localparam logic [7:0] OP_ILOAD_0   = 8'h1a;
   localparam logic [7:0] OP_ILOAD_3   = 8'h1d;
   localparam logic [7:0] OP_ISTORE_0  = 8'h3b;
   localparam logic [7:0] OP_ISTORE_3  = 8'h3e;
   localparam logic [7:0] OP_IADD      = 8'h60;
   localparam logic [7:0] OP_IAND      = 8'h7e;
   localparam logic [7:0] OP_IINC      = 8'h84;
   localparam logic [7:0] OP_IF_ICMPEQ = 8'h9f;
   localparam logic [7:0] OP_IF_ICMPNE = 8'ha0;
   localparam logic [7:0] OP_IF_ICMPLT = 8'ha1;
   localparam logic [7:0] OP_IF_ICMPGE = 8'ha2;
   localparam logic [7:0] OP_IF_ICMPGT = 8'ha3;
   localparam logic [7:0] OP_IF_ICMPLE = 8'ha4;
   localparam logic [7:0] OP_GOTO      = 8'ha7;
   localparam logic [7:0] OP_IRETURN   = 8'hac;
   localparam logic [7:0] OP_RETURN    = 8'hb1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_UNKNOWN   = 3'd1,
      ST_FINISHED  = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_UNDERFLOW = 3'd4,
      ST_BAD_LOCAL = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      STK_HOLD,
      STK_PUSH,
      STK_POP1,
      STK_POP2,
      STK_BINOP
   } stk_op_type;

   typedef struct packed {
      logic                en;
      stk_op_type          op;
      logic [WORD_W-1:0]   value;
   } stack_cmd_type;

   // bits needed to hold a stack count from 0 to depth
   function automatic int depth_width(input int depth);
      return $clog2(depth + 1);
   endfunction

   // bits needed to index the local variable bank
   function automatic int local_addr_width(input int count);
      return (count > 1) ? $clog2(count) : 1;
   endfunction

   // response payload width, padded to whole bytes
   function automatic int rsp_width(input int depth);
      int bits;
      bits = 3 + PC_W + 1 + WORD_W + depth_width(depth);
      return (bits + 7) & ~7;
   endfunction

endpackage

/* src/jibe_stack.sv */
// Operand stack as a shift register: entry 0 is always the top of stack.
// Depends on jibe_pkg for the stack command struct.
module jibe_stack #(
   parameter int STACK_DEPTH = jibe_pkg::DEF_STACK_DEPTH
) (
   input  logic                   clock,
   input  jibe_pkg::stack_cmd_type cmd,
   output logic [31:0]            top0,
   output logic [31:0]            top1,
   output logic [31:0]            next_top
);
   import jibe_pkg::*;

   logic [WORD_W-1:0] stk_ff [STACK_DEPTH];
   logic [WORD_W-1:0] stk_in [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_ent
      logic [WORD_W-1:0] below;
      logic [WORD_W-1:0] up1;
      logic [WORD_W-1:0] up2;
      logic [WORD_W-1:0] binop_val;

      if (i == 0) begin : g_top
         assign below     = cmd.value;
         assign binop_val = cmd.value;
      end else begin : g_deep
         assign below     = stk_ff[i-1];
         assign binop_val = up1;
      end

      // entries past the bottom hold their (unused) contents
      if (i + 1 < STACK_DEPTH) begin : g_up1
         assign up1 = stk_ff[i+1];
      end else begin : g_up1_end
         assign up1 = stk_ff[i];
      end

      if (i + 2 < STACK_DEPTH) begin : g_up2
         assign up2 = stk_ff[i+2];
      end else begin : g_up2_end
         assign up2 = stk_ff[i];
      end

      assign stk_in[i] = (cmd.op == STK_PUSH)  ? below :
                         (cmd.op == STK_POP1)  ? up1 :
                         (cmd.op == STK_POP2)  ? up2 :
                         (cmd.op == STK_BINOP) ? binop_val :
                                                 stk_ff[i];
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         stk_ff <= stk_in;
      end
   end

   assign top0     = stk_ff[0];
   assign top1     = stk_ff[1];
   assign next_top = stk_in[0];

endmodule

/* src/jibe_locals.sv */
// Local variable bank: memory with registered read, per-entry valid bits for
// the clear-at-reset behavior, and a bypass for a same-cycle write. Uses jibe_pkg.
module jibe_locals #(
   parameter int LOCAL_COUNT = jibe_pkg::DEF_LOCAL_COUNT
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  rd_en,
   input  logic [jibe_pkg::local_addr_width(LOCAL_COUNT)-1:0]    rd_addr,
   input  logic                                                  wr_en,
   input  logic [jibe_pkg::local_addr_width(LOCAL_COUNT)-1:0]    wr_addr,
   input  logic [31:0]                                           wr_data,
   output logic [31:0]                                           rd_data
);
   import jibe_pkg::*;

   logic [WORD_W-1:0]      mem [LOCAL_COUNT];
   logic [LOCAL_COUNT-1:0] valid_ff;
   logic [WORD_W-1:0]      mem_q_ff;
   logic [WORD_W-1:0]      byp_data_ff;
   logic                   bypass_ff;
   logic                   vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         bypass_ff <= 1'b0;
         vld_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            // a write landing in the read cycle wins over the stale array word
            bypass_ff <= wr_en && (wr_addr == rd_addr);
            vld_ff    <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = bypass_ff ? byp_data_ff : (vld_ff ? mem_q_ff : '0);

endmodule

/* src/jvm_int_bytecode_executor.sv */
// JVM int bytecode executor, top level. Uses jibe_pkg, jibe_stack, jibe_locals.
//
// Runs one JVM instruction per request (iconst, bipush, iload/istore 0-3, iadd,
// iand, iinc, if_icmp*, goto, return, ireturn) against an internal operand
// stack, local variable bank and 16-bit pc, and returns one response per
// request: status, next pc, branch taken, top of stack and stack depth.
// Throughput is one request per clock while rsp_tready is high. A request is
// taken into the input register and then executed; the response register is
// loaded by the execute cycle that writes stack, locals, pc and the response
// register together, and waits there while rsp_tready is low. The execute
// loop through the stack shift register and pc is what sets that rate; the
// local read is issued when the request is taken and bypasses a write from
// the instruction executing in the same cycle. The user must write the code
// size through the csr port only while no request is in flight; the block
// does not enforce this. Requests arriving once pc has reached the code size
// get status finished and change nothing.
module jvm_int_bytecode_executor #(
   parameter int STACK_DEPTH = jibe_pkg::DEF_STACK_DEPTH,
   parameter int LOCAL_COUNT = jibe_pkg::DEF_LOCAL_COUNT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // configuration: code size in bytes
   input  logic                                      csr_wr_en,
   input  logic [15:0]                               csr_wr_data,
   // request: [7:0] opcode, [15:8] operand_high, [23:16] operand_low
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [jibe_pkg::REQ_W-1:0]                req_tdata,
   // response: [2:0] status, [18:3] next_pc, [19] branch_taken,
   // [51:20] top_value, then depth, zero padded to bytes
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [jibe_pkg::rsp_width(STACK_DEPTH)-1:0] rsp_tdata
);
   import jibe_pkg::*;

   localparam int SCW   = depth_width(STACK_DEPTH);
   localparam int LW    = local_addr_width(LOCAL_COUNT);
   localparam int RSP_W = rsp_width(STACK_DEPTH);

   // ---------------- input register ----------------
   logic             a_valid_ff;
   logic [7:0]       a_op_ff;
   logic [7:0]       a_hi_ff;
   logic [7:0]       a_lo_ff;
   logic             fire;
   logic             accept;

   // ---------------- architectural state ----------------
   logic [PC_W-1:0]  pc_ff;
   logic [PC_W-1:0]  code_size_ff;
   logic [SCW-1:0]   count_ff;

   // ---------------- response register ----------------
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   // execute-stage signals
   status_type        status_in;
   logic [PC_W-1:0]   pc_in;
   logic [SCW-1:0]    count_in;
   logic              taken;
   logic              ret_val;
   logic [WORD_W-1:0] top_value;
   stack_cmd_type     scmd;
   logic              lw_en;
   logic [LW-1:0]     lw_addr;
   logic [WORD_W-1:0] lw_data;
   logic [WORD_W-1:0] top0;
   logic [WORD_W-1:0] top1;
   logic [WORD_W-1:0] next_top;
   logic [WORD_W-1:0] local_val;

   // request-side local read address
   logic [7:0]        req_op;
   logic [7:0]        ld_idx;
   logic              req_is_load;
   logic [LW-1:0]     rd_addr;

   assign fire       = a_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   // iload reads its fixed slot, everything else reads the iinc index
   assign req_op      = req_tdata[7:0];
   assign ld_idx      = req_op - OP_ILOAD_0;
   assign req_is_load = (req_op >= OP_ILOAD_0) && (req_op <= OP_ILOAD_3);
   assign rd_addr     = req_is_load ? ld_idx[LW-1:0] : req_tdata[8 +: LW];

   always_ff @(posedge clock) begin
      if (accept) begin
         a_op_ff <= req_tdata[7:0];
         a_hi_ff <= req_tdata[15:8];
         a_lo_ff <= req_tdata[23:16];
      end
      if (fire) begin
         rsp_data_ff <= RSP_W'({count_in, top_value, taken, pc_in, status_in});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         count_ff     <= '0;
         code_size_ff <= '0;
      end else begin
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (fire) begin
            a_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= pc_in;
            count_ff     <= count_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            code_size_ff <= csr_wr_data;
         end
      end
   end

   jibe_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock    (clock),
      .cmd      (scmd),
      .top0     (top0),
      .top1     (top1),
      .next_top (next_top)
   );

   jibe_locals #(
      .LOCAL_COUNT (LOCAL_COUNT)
   ) u_locals (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .wr_en   (lw_en),
      .wr_addr (lw_addr),
      .wr_data (lw_data),
      .rd_data (local_val)
   );

   // ---------------- execute ----------------
   always_comb begin
      logic              full;
      logic              has1;
      logic              has2;
      logic              cond;
      logic [PC_W-1:0]   offset;
      logic [7:0]        st_idx;
      logic [WORD_W-1:0] bipush_val;
      logic [WORD_W-1:0] inc_val;

      full       = (count_ff >= SCW'(STACK_DEPTH));
      has1       = (count_ff != '0);
      has2       = (count_ff > SCW'(1));
      offset     = {a_hi_ff, a_lo_ff};
      st_idx     = a_op_ff - OP_ISTORE_0;
      bipush_val = {{24{a_hi_ff[7]}}, a_hi_ff};
      inc_val    = {{24{a_lo_ff[7]}}, a_lo_ff};

      case (a_op_ff)
         OP_IF_ICMPEQ: cond = (top1 == top0);
         OP_IF_ICMPNE: cond = (top1 != top0);
         OP_IF_ICMPLT: cond = ($signed(top1) <  $signed(top0));
         OP_IF_ICMPGE: cond = ($signed(top1) >= $signed(top0));
         OP_IF_ICMPGT: cond = ($signed(top1) >  $signed(top0));
         default:      cond = ($signed(top1) <= $signed(top0));
      endcase

      status_in  = ST_OK;
      pc_in      = pc_ff;
      count_in   = count_ff;
      taken      = 1'b0;
      ret_val    = 1'b0;
      scmd.op    = STK_HOLD;
      scmd.value = '0;
      lw_en      = 1'b0;
      lw_addr    = '0;
      lw_data    = '0;

      if (pc_ff >= code_size_ff) begin
         status_in = ST_FINISHED;
      end else if (a_op_ff >= OP_ICONST_M1 && a_op_ff <= OP_ICONST_5) begin
         if (full) begin
            status_in = ST_OVERFLOW;
         end else begin
            scmd.op    = STK_PUSH;
            scmd.value = {24'd0, a_op_ff} - 32'd3;
            count_in   = count_ff + SCW'(1);
            pc_in      = pc_ff + 16'd1;
         end
      end else if (a_op_ff == OP_BIPUSH) begin
         if (full) begin
            status_in = ST_OVERFLOW;
         end else begin
            scmd.op    = STK_PUSH;
            scmd.value = bipush_val;
            count_in   = count_ff + SCW'(1);
            pc_in      = pc_ff + 16'd2;
         end
      end else if (a_op_ff >= OP_ILOAD_0 && a_op_ff <= OP_ILOAD_3) begin
         if (full) begin
            status_in = ST_OVERFLOW;
         end else begin
            scmd.op    = STK_PUSH;
            scmd.value = local_val;
            count_in   = count_ff + SCW'(1);
            pc_in      = pc_ff + 16'd1;
         end
      end else if (a_op_ff >= OP_ISTORE_0 && a_op_ff <= OP_ISTORE_3) begin
         if (!has1) begin
            status_in = ST_UNDERFLOW;
         end else begin
            scmd.op  = STK_POP1;
            lw_en    = 1'b1;
            lw_addr  = st_idx[LW-1:0];
            lw_data  = top0;
            count_in = count_ff - SCW'(1);
            pc_in    = pc_ff + 16'd1;
         end
      end else if (a_op_ff == OP_IADD || a_op_ff == OP_IAND) begin
         if (!has2) begin
            status_in = ST_UNDERFLOW;
         end else begin
            scmd.op    = STK_BINOP;
            scmd.value = (a_op_ff == OP_IADD) ? (top1 + top0) : (top1 & top0);
            count_in   = count_ff - SCW'(1);
            pc_in      = pc_ff + 16'd1;
         end
      end else if (a_op_ff == OP_IINC) begin
         if ({1'b0, a_hi_ff} >= 9'(LOCAL_COUNT)) begin
            status_in = ST_BAD_LOCAL;
         end else begin
            lw_en   = 1'b1;
            lw_addr = a_hi_ff[LW-1:0];
            lw_data = local_val + inc_val;
            pc_in   = pc_ff + 16'd3;
         end
      end else if (a_op_ff >= OP_IF_ICMPEQ && a_op_ff <= OP_IF_ICMPLE) begin
         if (!has2) begin
            status_in = ST_UNDERFLOW;
         end else begin
            scmd.op  = STK_POP2;
            count_in = count_ff - SCW'(2);
            taken    = cond;
            pc_in    = cond ? (pc_ff + offset) : (pc_ff + 16'd3);
         end
      end else if (a_op_ff == OP_GOTO) begin
         taken = 1'b1;
         pc_in = pc_ff + offset;
      end else if (a_op_ff == OP_RETURN) begin
         pc_in = code_size_ff;
      end else if (a_op_ff == OP_IRETURN) begin
         if (!has1) begin
            status_in = ST_UNDERFLOW;
         end else begin
            scmd.op  = STK_POP1;
            ret_val  = 1'b1;
            count_in = count_ff - SCW'(1);
            pc_in    = code_size_ff;
         end
      end else begin
         status_in = ST_UNKNOWN;
      end

      // state only moves when the response register takes the result
      scmd.en = fire;
      lw_en   = lw_en && fire;

      if (ret_val) begin
         top_value = top0;
      end else if (count_in != '0) begin
         top_value = next_top;
      end else begin
         top_value = '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
